>>> sv/bbrb_pkg.sv
// Shared types, constants and a helper function for the box blur block.
`default_nettype none
package bbrb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 15;
  localparam int CHANNELS       = 3;
  localparam int MAX_HEIGHT     = 1024;
  localparam int ROW_W          = 10;
  localparam int CFG_W          = 11;

  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic       frame_last;
  } out_word_t;

  typedef struct packed {
    logic [10:0] w;
    logic [10:0] h;
    logic [2:0]  rad;
    logic [7:0]  area;
    logic [15:0] thr;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_LAST,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // Reflect-101 mirroring of a padded index into 0..n-1.
  function automatic logic [11:0] mirror(input logic signed [13:0] idx_in,
                                         input logic [10:0] n);
    logic signed [13:0] idx;
    logic signed [13:0] top;
    idx = idx_in;
    top = $signed({3'b000, n}) - 14'sd1;
    if (idx < 14'sd0) idx = -idx;
    if (idx > top) idx = (top <<< 1) - idx;
    if (idx < 14'sd0) idx = 14'sd0;
    if (idx > top) idx = top;
    return idx[11:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/bbrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bbrb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> sv/bbrb_fifo.sv
// Small register queue that carries output jobs from front to back.
`default_nettype none
module bbrb_fifo #(
  parameter int WIDTH = 21
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic      [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign not_empty = (count != 2'd0);
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> sv/bbrb_front.sv
// Front end: accepts words, stores pixels and decides which words release an output.
`default_nettype none
module bbrb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  restart,
  input  wire bbrb_pkg::cfg_t        cfg,
  input  wire logic                  busy,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire bbrb_pkg::in_word_t    in_data,
  output logic                       wr_en,
  output logic [$clog2(MAX_WINDOW+1)+$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic [23:0]                wr_data,
  output logic                       push,
  output logic [$clog2(MAX_WIDTH)+10:0] job
);
  import bbrb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SB = $clog2(MAX_WINDOW + 1);

  logic [CW-1:0]    in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic             in_done, in_done_next;
  logic [CW-1:0]    out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic [15:0]      diff, diff_next;
  logic             accept;
  logic             last;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign wr_addr  = {in_row[SB-1:0], in_col};
  assign wr_data  = {in_data.chan2_in, in_data.chan1_in, in_data.chan0_in};
  assign job      = {last, out_row, out_col};

  always_comb begin
    wr_en        = 1'b0;
    push         = 1'b0;
    last         = 1'b0;
    in_col_next  = in_col;
    in_row_next  = in_row;
    in_done_next = in_done;
    out_col_next = out_col;
    out_row_next = out_row;
    diff_next    = diff;
    if (accept) begin
      if (!in_done) begin
        if (in_data.command == CMD_PIXEL) begin
          wr_en = 1'b1;
          if (14'(in_col) + 14'd1 >= 14'(cfg.w)) begin
            in_col_next = '0;
            if (11'(in_row) + 11'd1 >= cfg.h) begin
              in_row_next  = '0;
              in_done_next = 1'b1;
            end else begin
              in_row_next = in_row + 1'b1;
            end
          end else begin
            in_col_next = in_col + 1'b1;
          end
          if (in_done_next) begin
            push = 1'b1;
          end else if (diff + 16'd1 >= cfg.thr) begin
            push = 1'b1;
          end else begin
            diff_next = diff + 16'd1;
          end
        end
      end else begin
        push = 1'b1;
      end
    end
    if (push) begin
      if (14'(out_col) + 14'd1 >= 14'(cfg.w)) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
        if (11'(out_row) + 11'd1 >= cfg.h) last = 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
    if (last) begin
      in_col_next  = '0;
      in_row_next  = '0;
      in_done_next = 1'b0;
      out_col_next = '0;
      out_row_next = '0;
      diff_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      in_done <= 1'b0;
      out_col <= '0;
      out_row <= '0;
      diff    <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      in_done <= in_done_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      diff    <= diff_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/bbrb_back.sv
// Back end: sums the mirrored window from the row store and divides by the area.
`default_nettype none
module bbrb_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bbrb_pkg::cfg_t        cfg,
  input  wire logic                  job_ready,
  input  wire logic [$clog2(MAX_WIDTH)+10:0] job,
  output logic                       pop,
  output logic                       busy,
  output logic                       rd_en,
  output logic [$clog2(MAX_WINDOW+1)+$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  wire logic [23:0]           rd_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output bbrb_pkg::out_word_t        out_data
);
  import bbrb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SB = $clog2(MAX_WINDOW + 1);

  back_state_t      state, state_next;
  logic [CW-1:0]    job_col;
  logic [ROW_W-1:0] job_row;
  logic             job_last;
  logic signed [3:0] dx, dy, rad_s;
  logic             rd_valid;
  logic [15:0]      acc [CHANNELS];
  logic [15:0]      acc_sum [CHANNELS];
  logic [15:0]      rem [CHANNELS];
  logic [7:0]       quo [CHANNELS];
  logic [2:0]       step;
  logic [11:0]      row_m, col_m;
  logic             last_issue;
  logic             load_out;

  assign rad_s      = $signed({1'b0, cfg.rad});
  assign last_issue = (dx == rad_s) && (dy == rad_s);
  assign busy       = (state != BK_IDLE);
  assign row_m      = mirror($signed({4'b0000, job_row}) + 14'(dy), cfg.h);
  assign col_m      = mirror($signed(14'(job_col)) + 14'(dx), cfg.w);
  assign rd_addr    = {row_m[SB-1:0], col_m[CW-1:0]};

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      acc_sum[i] = acc[i] + 16'(rd_data[8*i +: 8]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_ready) state_next = BK_READ;
      BK_READ: if (last_issue) state_next = BK_LAST;
      BK_LAST: state_next = BK_DIV;
      BK_DIV:  if (step == 3'd0) state_next = BK_OUT;
      BK_OUT:  if (!out_valid || !out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: pop = job_ready;
      BK_READ: rd_en = 1'b1;
      BK_OUT:  load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {job_last, job_row, job_col} <= job;
      dx <= -rad_s;
      dy <= -rad_s;
      for (int i = 0; i < CHANNELS; i++) acc[i] <= '0;
    end
    if (state == BK_READ) begin
      if (dx == rad_s) begin
        dx <= -rad_s;
        dy <= dy + 4'sd1;
      end else begin
        dx <= dx + 4'sd1;
      end
      if (rd_valid) begin
        for (int i = 0; i < CHANNELS; i++) acc[i] <= acc_sum[i];
      end
    end
    if (state == BK_LAST) begin
      for (int i = 0; i < CHANNELS; i++) rem[i] <= acc_sum[i];
      step <= 3'd7;
    end
    if (state == BK_DIV) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (24'(rem[i]) >= (24'(cfg.area) << step)) begin
          rem[i] <= 16'(24'(rem[i]) - (24'(cfg.area) << step));
          quo[i] <= {quo[i][6:0], 1'b1};
        end else begin
          quo[i] <= {quo[i][6:0], 1'b0};
        end
      end
      step <= step - 3'd1;
    end
    if (load_out) begin
      out_data.chan0_out  <= quo[0];
      out_data.chan1_out  <= quo[1];
      out_data.chan2_out  <= quo[2];
      out_data.frame_last <= job_last;
    end
    if (rst) begin
      state     <= BK_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == BK_READ);
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> sv/box_blur_reflect_border.sv
// Top level of the streaming box blur with reflect-101 borders.
// Each word is taken while in_stall is low; a word that releases an output keeps the input
// stalled until the back end has done one row store read per window tap, run an 8-step
// divider and loaded the output register, which waits while the output is stalled.
// The result lags the input by rad rows and rad pixels.
// Reset is synchronous; it clears positions and loads window 3, 640 by 480.
`default_nettype none
module box_blur_reflect_border #(
  parameter int MAX_WIDTH  = bbrb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = bbrb_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [10:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bbrb_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bbrb_pkg::out_word_t      out_data
);
  import bbrb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SB = $clog2(MAX_WINDOW + 1);
  localparam int AW = SB + CW;
  localparam int JW = CW + 11;
  localparam logic [3:0] WIN_CAP =
    4'((MAX_WINDOW > 15) ? 15 : (MAX_WINDOW - ((MAX_WINDOW % 2 == 0) ? 1 : 0)));

  logic [3:0]    window_size;
  logic [10:0]   image_width;
  logic [10:0]   image_height;
  logic          restart;
  cfg_t          cfg;
  logic [3:0]    win, win_c;
  logic [2:0]    rad;
  logic [3:0]    side;
  logic          wr_en, rd_en, push, pop, job_ready, back_busy;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [23:0]   wr_data, rd_data;
  logic [JW-1:0] job_in, job_out;

  assign restart = cfg_write && (cfg_index == REG_WINDOW_SIZE ||
                   cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= 4'd3;
      image_width  <= 11'd640;
      image_height <= 11'd480;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  window_size  <= cfg_data[3:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.w = image_width;
    if (image_width == 11'd0) cfg.w = 11'd1;
    else if (13'(image_width) > 13'(MAX_WIDTH)) cfg.w = 11'(MAX_WIDTH);
    cfg.h = image_height;
    if (image_height == 11'd0) cfg.h = 11'd1;
    else if (image_height > 11'(MAX_HEIGHT)) cfg.h = 11'(MAX_HEIGHT);
    win   = window_size | 4'd1;
    win_c = (7'(win) > 7'(MAX_WINDOW)) ? WIN_CAP : win;
    rad   = win_c[3:1];
    if (11'(rad) > cfg.w - 11'd1) rad = 3'(cfg.w - 11'd1);
    if (11'(rad) > cfg.h - 11'd1) rad = 3'(cfg.h - 11'd1);
    cfg.rad  = rad;
    side     = {rad, 1'b1};
    cfg.area = 8'(side) * 8'(side);
    cfg.thr  = 16'(14'(rad) * 14'(cfg.w)) + 16'(rad) + 16'd1;
  end

  bbrb_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .restart(restart),
    .cfg(cfg),
    .busy(job_ready || back_busy),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .push(push),
    .job(job_in)
  );

  bbrb_ram #(
    .WIDTH(24),
    .DEPTH(1 << AW)
  ) u_row_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bbrb_fifo #(
    .WIDTH(JW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(job_in),
    .pop(pop),
    .not_empty(job_ready),
    .pop_data(job_out)
  );

  bbrb_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .job_ready(job_ready),
    .job(job_out),
    .pop(pop),
    .busy(back_busy),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

>>> dv/tb_box_blur_reflect_border.sv
// Testbench for box_blur_reflect_border: directed and random frames checked against a built-in blur predictor.
`timescale 1ns / 1ps
module tb_box_blur_reflect_border;
  import bbrb_pkg::*;

  localparam int STORE_ROWS = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  class blur_scoreboard;
    logic [23:0] pixel_rows[STORE_ROWS][DEF_MAX_WIDTH];
    out_word_t pending_q[$];
    logic [3:0] window_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    int in_row, in_col, out_row, out_col;
    bit frame_in_done;
    int errors;
    int accepted;

    function void restart_frame();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      frame_in_done = 0;
    endfunction

    function void init_regs();
      window_reg = 4'd3;
      width_reg = 11'd640;
      height_reg = 11'd480;
      errors = 0;
      accepted = 0;
      restart_frame();
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] val);
      if (idx == REG_WINDOW_SIZE) window_reg = val[3:0];
      else if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
      else return;
      restart_frame();
    endfunction

    function int reflect(int idx, int n);
      if (idx < 0) idx = -idx;
      if (idx > n - 1) idx = 2 * (n - 1) - idx;
      if (idx < 0) idx = 0;
      if (idx > n - 1) idx = n - 1;
      return idx;
    endfunction

    function void note_input(in_word_t x);
      int w, h, win, rad, area, got, k, row, col;
      int sums[3];
      logic [23:0] px;
      out_word_t res;
      accepted++;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      win = window_reg | 1;
      if (win > DEF_MAX_WINDOW) win = DEF_MAX_WINDOW;
      rad = win / 2;
      if (rad > w - 1) rad = w - 1;
      if (rad > h - 1) rad = h - 1;
      area = (2 * rad + 1) * (2 * rad + 1);
      if (!frame_in_done) begin
        if (x.command == CMD_DRAIN) return;
        pixel_rows[in_row % STORE_ROWS][in_col] = {x.chan2_in, x.chan1_in, x.chan0_in};
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
          if (in_row >= h) begin
            in_row = 0;
            frame_in_done = 1;
          end
        end
        if (!frame_in_done) begin
          got = in_row * w + in_col;
          k = out_row * w + out_col;
          if (got < k + rad * w + rad + 1) return;
        end
      end
      sums = '{0, 0, 0};
      for (int dy = -rad; dy <= rad; dy++) begin
        row = reflect(out_row + dy, h);
        for (int dx = -rad; dx <= rad; dx++) begin
          col = reflect(out_col + dx, w);
          px = pixel_rows[row % STORE_ROWS][col];
          sums[0] += px[7:0];
          sums[1] += px[15:8];
          sums[2] += px[23:16];
        end
      end
      res.chan0_out = 8'(sums[0] / area);
      res.chan1_out = 8'(sums[1] / area);
      res.chan2_out = 8'(sums[2] / area);
      res.frame_last = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) res.frame_last = 1'b1;
      end
      pending_q.push_back(res);
      if (res.frame_last) restart_frame();
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending_q.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.chan0_out !== exp_w.chan0_out) begin
        $error("chan0_out expected %0d actual %0d", exp_w.chan0_out, got.chan0_out);
        errors++;
      end
      if (got.chan1_out !== exp_w.chan1_out) begin
        $error("chan1_out expected %0d actual %0d", exp_w.chan1_out, got.chan1_out);
        errors++;
      end
      if (got.chan2_out !== exp_w.chan2_out) begin
        $error("chan2_out expected %0d actual %0d", exp_w.chan2_out, got.chan2_out);
        errors++;
      end
      if (got.frame_last !== exp_w.frame_last) begin
        $error("frame_last expected %0d actual %0d", exp_w.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [10:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;

  blur_scoreboard sb;
  int idle_cycles;
  int burst_left;
  bit hold_request;

  box_blur_reflect_border dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_pixel();
    in_word_t x;
    x.command = CMD_PIXEL;
    x.chan0_in = pick_channel();
    x.chan1_in = pick_channel();
    x.chan2_in = pick_channel();
    return x;
  endfunction

  function automatic in_word_t make_drain();
    in_word_t x;
    x = make_pixel();
    x.command = CMD_DRAIN;
    return x;
  endfunction

  task automatic send_word(in_word_t x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    sb.note_input(x);
  endtask

  task automatic wait_results();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_write <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic setup(logic [10:0] win, logic [10:0] w, logic [10:0] h);
    wait_results();
    write_reg(REG_WINDOW_SIZE, win);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Sends count pixels with some stray drains, then, while the frame input is done, sends drains with the odd pixel.
  task automatic run_frame(int count, int noise_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(make_drain());
      send_word(make_pixel());
    end
    while (sb.frame_in_done) begin
      if ($urandom_range(0, 9) == 0) send_word(make_pixel());
      else send_word(make_drain());
    end
  endtask

  initial begin
    in_word_t x;
    int w, h, pix;
    sb = new();
    sb.init_regs();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WINDOW_SIZE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    hold_request = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    setup(11'd15, 11'd0, 11'd0);
    send_word(make_drain());
    x = '{CMD_PIXEL, 8'd255, 8'd255, 8'd255};
    send_word(x);
    x = '{CMD_PIXEL, 8'd0, 8'd0, 8'd0};
    send_word(x);
    x = '{CMD_PIXEL, 8'd255, 8'd0, 8'd170};
    send_word(x);
    setup(11'd2, 11'd8, 11'd8);
    for (int i = 0; i < 64; i++) begin
      if (i == 5) send_word(make_drain());
      x.command = CMD_PIXEL;
      x.chan0_in = (i % 2) ? 8'd255 : 8'd0;
      x.chan1_in = (i % 3) ? 8'd0 : 8'd255;
      x.chan2_in = 8'(i * 37);
      send_word(x);
    end
    send_word(make_pixel());
    while (sb.frame_in_done) send_word(make_drain());

    setup(11'd14, 11'd8, 11'd8);
    run_frame(64, 5);
    setup(11'd1, 11'd1024, 11'd8);
    run_frame(120, 0);
    setup(11'd0, 11'd8, 11'd1024);
    run_frame(120, 0);
    setup(11'd0, 11'd2047, 11'd2047);
    run_frame(40, 0);
    setup(11'd15, 11'd16, 11'd16);
    hold_request = 1;
    run_frame(256, 3);

    while (sb.accepted < 1150) begin
      w = $urandom_range(8, 24);
      h = $urandom_range(8, 16);
      setup(11'($urandom_range(0, 15)), 11'(w), 11'(h));
      pix = w * h;
      if ($urandom_range(0, 9) == 0) pix = $urandom_range(1, pix - 1);
      run_frame(pix, 5);
    end

    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int mode, stretch;
    out_stall = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 0;
        @(negedge clk) out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
      end
      mode = $urandom_range(0, 2);
      stretch = $urandom_range(10, 200);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
